// ===== rtl/core/mcr_pkg.sv =====
// Package for the midpoint circle rasterizer: widths, request codes and the
// packed item types of the input and result channels. No dependencies.
package mcr_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COLOR_WIDTH = 32;
  // decision term carries two guard bits so it never wraps
  localparam int DEC_WIDTH   = COORD_WIDTH + 2;
  // scratch width for the decision update before it is cut back
  localparam int WORK_WIDTH  = COORD_WIDTH + 4;
  localparam int REQ_WIDTH   = 2;
  localparam int IDX_WIDTH   = 3;

  localparam logic [REQ_WIDTH-1:0] REQ_OUTLINE = 2'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_FILL    = 2'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_STEP    = 2'd2;

  localparam logic [IDX_WIDTH-1:0] IDX_LAST_FILL    = 3'd3;
  localparam logic [IDX_WIDTH-1:0] IDX_LAST_OUTLINE = 3'd7;

  typedef struct packed {
    logic        [REQ_WIDTH-1:0]   req_type;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] radius;
    logic        [COLOR_WIDTH-1:0] draw_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_start;
    logic signed [COORD_WIDTH-1:0] y_row;
    logic signed [COORD_WIDTH-1:0] x_end;
    logic        [COLOR_WIDTH-1:0] pixel_color;
    logic                          has_pixels;
    logic                          last_of_step;
    logic                          circle_done;
  } out_item_t;

endpackage

// ===== rtl/core/midpoint_circle_raster_core.sv =====
// Midpoint circle rasterizer top level: circle state, step job register and
// result register. Depends on mcr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes requests: start outline,
//   start filled, or advance one octant step (codes two and three both mean
//   advance). A start with radius >= 0 loads the circle and yields no item;
//   a start with a negative radius, or an advance with no circle running,
//   yields one empty item (has_pixels 0, last and done set).
//   Result channel (out_valid/out_ready/out_data) gives one item per cycle
//   while out_ready is high: 8 points per outline step, 4 spans per filled step.
//   Path: the first item of a step reaches out_valid through the job
//   register, then the result register, after the request is accepted.
//   Throughput: one result per cycle from the job register while out_ready
//   is high; the next request is taken in the cycle the last item of the
//   current job moves into the result register. Starts with radius >= 0
//   need a free job slot as well.
//   Stall: when out_ready is low the result register holds, the job register
//   waits, and in_ready drops once the job cannot retire.
//   Reset (rst_n low, synchronous): circle state clears to zero, not busy,
//   and both the job and result registers empty.
module midpoint_circle_raster_core
  import mcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // ---------------------------------------------------------------- state
  logic                          busy_r, busy_nxt;
  logic                          fill_r, fill_nxt;
  logic signed [COORD_WIDTH-1:0] cx_r, cx_nxt;
  logic signed [COORD_WIDTH-1:0] cy_r, cy_nxt;
  logic        [COLOR_WIDTH-1:0] color_r, color_nxt;
  logic signed [COORD_WIDTH-1:0] major_r, major_nxt;
  logic signed [COORD_WIDTH-1:0] minor_r, minor_nxt;
  logic signed [DEC_WIDTH-1:0]   dec_r, dec_nxt;

  // ----------------------------------------------------------- job register
  // Holds one step's operands while its results drain, one per cycle when out_ready is high.
  logic                          job_valid_r, job_valid_nxt;
  logic                          job_empty_r, job_empty_nxt;
  logic                          job_fill_r, job_fill_nxt;
  logic                          job_done_r, job_done_nxt;
  logic        [IDX_WIDTH-1:0]   job_idx_r, job_idx_nxt;
  logic signed [COORD_WIDTH-1:0] job_a_r, job_a_nxt;
  logic signed [COORD_WIDTH-1:0] job_b_r, job_b_nxt;
  logic signed [COORD_WIDTH-1:0] job_cx_r, job_cx_nxt;
  logic signed [COORD_WIDTH-1:0] job_cy_r, job_cy_nxt;
  logic        [COLOR_WIDTH-1:0] job_color_r, job_color_nxt;

  // -------------------------------------------------------- result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // ------------------------------------------------------- request decode
  logic in_fire;
  logic is_start;
  logic job_last;
  logic out_load;

  assign is_start = (in_data.req_type == REQ_OUTLINE) || (in_data.req_type == REQ_FILL);

  // job retires when its final item moves into the result register
  assign out_load = job_valid_r && (!out_valid_r || out_ready);
  assign job_last = job_empty_r ||
                    (job_fill_r ? (job_idx_r == IDX_LAST_FILL)
                                : (job_idx_r == IDX_LAST_OUTLINE));
  assign in_ready = !job_valid_r || (out_load && job_last);
  assign in_fire  = in_valid && in_ready;

  // ------------------------------------------------------ start decision
  logic signed [DEC_WIDTH-1:0] radius_ext;
  logic signed [DEC_WIDTH-1:0] dec_start;

  assign radius_ext = DEC_WIDTH'(in_data.radius);
  assign dec_start  = DEC_WIDTH'(1) - radius_ext;

  // ------------------------------------------------------- step update
  // minor grows by one; major shrinks when the decision term is positive.
  logic signed [COORD_WIDTH:0]   minor_inc;
  logic signed [COORD_WIDTH-1:0] major_dec;
  logic signed [COORD_WIDTH-1:0] minor_wrap;
  logic signed [COORD_WIDTH-1:0] major_step;
  logic signed [WORK_WIDTH-1:0]  dec_w, minor_w, major_w;
  logic signed [WORK_WIDTH-1:0]  nd_keep, nd_shrink;
  logic                          dec_pos;
  logic                          step_ok;
  logic                          step_done;

  assign minor_inc  = (COORD_WIDTH + 1)'(minor_r) + (COORD_WIDTH + 1)'(1);
  assign major_dec  = major_r - COORD_WIDTH'(1);
  assign minor_wrap = minor_inc[COORD_WIDTH-1:0];
  assign dec_pos    = !dec_r[DEC_WIDTH-1] && (dec_r != '0);
  assign major_step = dec_pos ? major_dec : major_r;

  assign dec_w     = WORK_WIDTH'(dec_r);
  assign minor_w   = WORK_WIDTH'(minor_inc);
  assign major_w   = WORK_WIDTH'(major_dec);
  assign nd_keep   = dec_w + (minor_w <<< 1) + WORK_WIDTH'(1);
  assign nd_shrink = dec_w + ((minor_w - major_w) <<< 1) + WORK_WIDTH'(1);

  assign step_ok   = busy_r && (minor_r <= major_r);
  assign step_done = minor_wrap > major_step;

  always_comb begin
    busy_nxt      = busy_r;
    fill_nxt      = fill_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    color_nxt     = color_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    dec_nxt       = dec_r;

    job_valid_nxt = job_valid_r;
    job_empty_nxt = job_empty_r;
    job_fill_nxt  = job_fill_r;
    job_done_nxt  = job_done_r;
    job_idx_nxt   = job_idx_r;
    job_a_nxt     = job_a_r;
    job_b_nxt     = job_b_r;
    job_cx_nxt    = job_cx_r;
    job_cy_nxt    = job_cy_r;
    job_color_nxt = job_color_r;

    // draining: step the job index or retire the job
    if (out_load) begin
      if (job_last) begin
        job_valid_nxt = 1'b0;
      end else begin
        job_idx_nxt = job_idx_r + IDX_WIDTH'(1);
      end
    end

    if (in_fire) begin
      job_idx_nxt = '0;
      if (is_start) begin
        fill_nxt  = (in_data.req_type == REQ_FILL);
        cx_nxt    = in_data.center_x;
        cy_nxt    = in_data.center_y;
        color_nxt = in_data.draw_color;
        major_nxt = in_data.radius;
        minor_nxt = '0;
        dec_nxt   = dec_start;
        busy_nxt  = !in_data.radius[COORD_WIDTH-1];
        // negative radius: a single empty item
        if (in_data.radius[COORD_WIDTH-1]) begin
          job_valid_nxt = 1'b1;
          job_empty_nxt = 1'b1;
          job_done_nxt  = 1'b1;
          job_color_nxt = in_data.draw_color;
        end
      end else if (!step_ok) begin
        // advance with nothing left to draw
        busy_nxt      = 1'b0;
        job_valid_nxt = 1'b1;
        job_empty_nxt = 1'b1;
        job_done_nxt  = 1'b1;
        job_color_nxt = color_r;
      end else begin
        minor_nxt     = minor_wrap;
        major_nxt     = major_step;
        dec_nxt       = dec_pos ? nd_shrink[DEC_WIDTH-1:0] : nd_keep[DEC_WIDTH-1:0];
        busy_nxt      = !step_done;
        job_valid_nxt = 1'b1;
        job_empty_nxt = 1'b0;
        job_fill_nxt  = fill_r;
        job_done_nxt  = step_done;
        job_a_nxt     = major_r;
        job_b_nxt     = minor_r;
        job_cx_nxt    = cx_r;
        job_cy_nxt    = cy_r;
        job_color_nxt = color_r;
      end
    end
  end

  // ----------------------------------------------------- result selection
  logic signed [COORD_WIDTH-1:0] cx_pa, cx_ma, cx_pb, cx_mb;
  logic signed [COORD_WIDTH-1:0] cy_pa, cy_ma, cy_pb, cy_mb;
  logic signed [COORD_WIDTH-1:0] sel_xs, sel_y, sel_xe;

  assign cx_pa = job_cx_r + job_a_r;
  assign cx_ma = job_cx_r - job_a_r;
  assign cx_pb = job_cx_r + job_b_r;
  assign cx_mb = job_cx_r - job_b_r;
  assign cy_pa = job_cy_r + job_a_r;
  assign cy_ma = job_cy_r - job_a_r;
  assign cy_pb = job_cy_r + job_b_r;
  assign cy_mb = job_cy_r - job_b_r;

  always_comb begin
    sel_xs = '0;
    sel_y  = '0;
    sel_xe = '0;
    if (job_empty_r) begin
      sel_xs = '0;
    end else if (job_fill_r) begin
      unique case (job_idx_r[1:0])
        2'd0: begin sel_xs = cx_ma; sel_y = cy_mb; sel_xe = cx_pa; end
        2'd1: begin sel_xs = cx_ma; sel_y = cy_pb; sel_xe = cx_pa; end
        2'd2: begin sel_xs = cx_mb; sel_y = cy_ma; sel_xe = cx_pb; end
        default: begin sel_xs = cx_mb; sel_y = cy_pa; sel_xe = cx_pb; end
      endcase
    end else begin
      unique case (job_idx_r)
        3'd0: begin sel_xs = cx_pa; sel_y = cy_pb; sel_xe = cx_pa; end
        3'd1: begin sel_xs = cx_ma; sel_y = cy_pb; sel_xe = cx_ma; end
        3'd2: begin sel_xs = cx_ma; sel_y = cy_mb; sel_xe = cx_ma; end
        3'd3: begin sel_xs = cx_pa; sel_y = cy_mb; sel_xe = cx_pa; end
        3'd4: begin sel_xs = cx_pb; sel_y = cy_pa; sel_xe = cx_pb; end
        3'd5: begin sel_xs = cx_mb; sel_y = cy_pa; sel_xe = cx_mb; end
        3'd6: begin sel_xs = cx_mb; sel_y = cy_ma; sel_xe = cx_mb; end
        default: begin sel_xs = cx_pb; sel_y = cy_ma; sel_xe = cx_pb; end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.x_start      = sel_xs;
      out_data_nxt.y_row        = sel_y;
      out_data_nxt.x_end        = sel_xe;
      out_data_nxt.pixel_color  = job_color_r;
      out_data_nxt.has_pixels   = !job_empty_r;
      out_data_nxt.last_of_step = job_last;
      out_data_nxt.circle_done  = job_done_r;
    end
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fill_r      <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      color_r     <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      dec_r       <= '0;
      job_valid_r <= 1'b0;
      job_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      fill_r      <= fill_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      color_r     <= color_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      dec_r       <= dec_nxt;
      job_valid_r <= job_valid_nxt;
      job_idx_r   <= job_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    job_empty_r <= job_empty_nxt;
    job_fill_r  <= job_fill_nxt;
    job_done_r  <= job_done_nxt;
    job_a_r     <= job_a_nxt;
    job_b_r     <= job_b_nxt;
    job_cx_r    <= job_cx_nxt;
    job_cy_r    <= job_cy_nxt;
    job_color_r <= job_color_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/mcr_checker.sv =====
// Port-level checks for the midpoint circle rasterizer, bound to the top
// level. Depends on mcr_pkg and midpoint_circle_raster_core.
module mcr_checker
  import mcr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // result channel comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a waiting request holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request item dropped or changed");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // a step's items follow back to back with the same done flag and color
  a_step_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_step
    |=> out_valid && out_data.circle_done == $past(out_data.circle_done)
        && out_data.pixel_color == $past(out_data.pixel_color))
    else $error("step items broken up or inconsistent");

  // an empty item ends the step and the circle
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_pixels
    |-> out_data.last_of_step && out_data.circle_done
        && out_data.x_start == '0 && out_data.y_row == '0 && out_data.x_end == '0)
    else $error("malformed empty item");

endmodule

bind midpoint_circle_raster_core mcr_checker u_mcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
